// ----- sv/button_press_classifier_unit_assert.svh -----
// ----------------------------------------------------------------------------
// button press classifier assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpc assertion failed");

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpc assertion failed");

`endif

// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// types, register indexes, event codes and counter helpers for the
// button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

    // elapsed counter width
    localparam int TIMER_BITS    = 17;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int EVENT_BITS    = 3;

    typedef logic [TIMER_BITS-1:0]    t_timer;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_LONG     = 3'd1,
        CFG_DOUBLE   = 3'd2,
        CFG_HOLD     = 3'd3,
        CFG_ACTIVE   = 3'd4
    } t_cfg_idx;

    // latched event codes
    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE   = 3'd0,
        EV_SHORT  = 3'd1,
        EV_LONG   = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_HOLD   = 3'd4
    } t_event;

    // register reset values
    localparam t_cfg_data DEBOUNCE_RST = 16'd5;
    localparam t_cfg_data LONG_RST     = 16'd50;
    localparam t_cfg_data DOUBLE_RST   = 16'd30;
    localparam t_cfg_data HOLD_RST     = 16'd500;

    localparam t_timer TIMER_MAX = {TIMER_BITS{1'b1}};

    // saturating increment
    function automatic t_timer timer_adv(input t_timer v);
        return (v == TIMER_MAX) ? v : t_timer'(v + 1'b1);
    endfunction

    // threshold widened to counter width
    function automatic t_timer thr(input t_cfg_data v);
        return t_timer'(v);
    endfunction

endpackage

// ----- sv/button_press_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// debounces a polled button level and reports short, long, double and hold
// presses through a latched event code
// ----------------------------------------------------------------------------
// Each input word is one poll tick (raw level plus fetch flag). The whole
// tick update - debounce, press classification and the double-press window -
// is one pass of logic from the state registers into the output register, so
// a word is taken on every clock unless the input is stalled; its event code
// appears on the output in the following cycle. The output register stalls
// the input only while a result is held and the output side stalls. All
// thresholds count ticks; the 17-bit elapsed counters saturate. The user must
// write configuration while no word is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module button_press_classifier_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  bpc_pkg::t_cfg_idx    i_cfg_idx,
    input  bpc_pkg::t_cfg_data   i_cfg_data,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_button_level,
    input  logic                 i_fetch,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output bpc_pkg::t_event      o_event_code
);
    import bpc_pkg::*;

`include "button_press_classifier_unit_assert.svh"

    // configuration registers
    t_cfg_data r_debounce;
    t_cfg_data r_long;
    t_cfg_data r_double;
    t_cfg_data r_hold;
    logic      r_active;

    // tick state
    logic   r_last_raw,  n_last_raw;
    t_timer r_stable,    n_stable;
    t_timer r_press,     n_press;
    t_timer r_pending,   n_pending;
    logic   r_pressed,   n_pressed;
    logic   r_long_rep,  n_long_rep;
    logic   r_hold_rep,  n_hold_rep;
    logic   r_short,     n_short;
    t_event r_latched,   n_latched;
    t_event n_out_code;

    // output register
    logic   r_out_valid;
    t_event r_out_code;

    logic in_acc;

    // handshake
    assign o_stall      = r_out_valid & i_stall;
    assign in_acc       = i_valid & ~o_stall;
    assign o_valid      = r_out_valid;
    assign o_event_code = r_out_code;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_long     <= LONG_RST;
            r_double   <= DOUBLE_RST;
            r_hold     <= HOLD_RST;
            r_active   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_LONG:     r_long     <= i_cfg_data;
                CFG_DOUBLE:   r_double   <= i_cfg_data;
                CFG_HOLD:     r_hold     <= i_cfg_data;
                CFG_ACTIVE:   r_active   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // one tick of debounce and classification
    always_comb begin
        n_last_raw = r_last_raw;
        n_stable   = timer_adv(r_stable);
        n_press    = timer_adv(r_press);
        n_pending  = timer_adv(r_pending);
        n_pressed  = r_pressed;
        n_long_rep = r_long_rep;
        n_hold_rep = r_hold_rep;
        n_short    = r_short;
        n_latched  = r_latched;

        if (i_button_level != r_last_raw) begin
            n_stable   = '0;
            n_last_raw = i_button_level;
        end else if (n_stable >= thr(r_debounce)) begin
            if (i_button_level == r_active) begin
                // stable press: start, then hold before long
                if (!r_pressed) begin
                    n_pressed  = 1'b1;
                    n_long_rep = 1'b0;
                    n_hold_rep = 1'b0;
                    n_press    = '0;
                end else if (!r_hold_rep && n_press >= thr(r_hold)) begin
                    n_latched  = EV_HOLD;
                    n_hold_rep = 1'b1;
                    n_short    = 1'b0;
                end else if (!r_long_rep && n_press >= thr(r_long)) begin
                    n_latched  = EV_LONG;
                    n_long_rep = 1'b1;
                end
            end else begin
                // stable release: double or open short window
                if (r_pressed && !r_long_rep && !r_hold_rep) begin
                    if (r_short && n_pending <= thr(r_double)) begin
                        n_latched = EV_DOUBLE;
                        n_short   = 1'b0;
                    end else begin
                        n_short   = 1'b1;
                        n_pending = '0;
                    end
                end
                n_pressed  = 1'b0;
                n_long_rep = 1'b1;
                n_hold_rep = 1'b1;
            end
        end

        // short window expiry
        if (n_short && n_pending > thr(r_double)) begin
            n_latched = EV_SHORT;
            n_short   = 1'b0;
        end

        n_out_code = n_latched;
        if (i_fetch) begin
            n_latched = EV_NONE;
        end
    end

    // state update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= 1'b1;
            r_stable   <= '0;
            r_press    <= '0;
            r_pending  <= '0;
            r_pressed  <= 1'b0;
            r_long_rep <= 1'b0;
            r_hold_rep <= 1'b0;
            r_short    <= 1'b0;
            r_latched  <= EV_NONE;
        end else if (in_acc) begin
            r_last_raw <= n_last_raw;
            r_stable   <= n_stable;
            r_press    <= n_press;
            r_pending  <= n_pending;
            r_pressed  <= n_pressed;
            r_long_rep <= n_long_rep;
            r_hold_rep <= n_hold_rep;
            r_short    <= n_short;
            r_latched  <= n_latched;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_code <= n_out_code;
        end
    end

    // checks
    `BPC_ASSERT_NEXT(a_acc_gives_word, i_clk, i_rst_n, in_acc, o_valid)
    `BPC_ASSERT_NEXT(a_fetch_clears, i_clk, i_rst_n, in_acc && i_fetch, r_latched == EV_NONE)
    `BPC_ASSERT_NEXT(a_out_matches_latch, i_clk, i_rst_n, in_acc && !i_fetch,
        o_event_code == r_latched)
    `BPC_ASSERT_NEXT(a_change_restarts, i_clk, i_rst_n,
        in_acc && (i_button_level != r_last_raw), r_stable == '0)

endmodule

// ----- tb/tb_button_press_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier_unit
// self-checking bench for the button press classifier: every accepted poll
// word is run through a tick-accurate press classifier kept in a small
// scoreboard, and every event code that leaves the block is compared with the
// oldest predicted one. Stimulus is a directed opening followed by random
// press/release sequences over several threshold settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_unit;
    import bpc_pkg::*;

    localparam int        IDLE_MAX         = 13;
    localparam int        HOLD_OFF_CYCLES  = 48;
    localparam int        WATCHDOG_LIMIT   = 1000;
    localparam int        SETTLE_CYCLES    = 4;
    localparam int        RANDOM_PHASES    = 6;
    localparam int        WORDS_PER_PHASE  = 95;
    localparam int        MAX_PRINTED      = 100;
    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE = 3'd6;

    // press classifier prediction and event checking
    class press_event_board;
        t_cfg_data  debounce_thr;
        t_cfg_data  long_thr;
        t_cfg_data  double_thr;
        t_cfg_data  hold_thr;
        logic       active_lvl;

        logic       raw_prev;
        t_timer     stable_cnt;
        t_timer     press_cnt;
        t_timer     window_cnt;
        logic       pressed;
        logic       long_done;
        logic       hold_done;
        logic       short_armed;
        t_event     latched;

        t_event     event_q[$];
        int         errors;
        int         ticks;
        int         short_n;
        int         long_n;
        int         double_n;
        int         hold_n;

        function new();
            debounce_thr = DEBOUNCE_RST;
            long_thr     = LONG_RST;
            double_thr   = DOUBLE_RST;
            hold_thr     = HOLD_RST;
            active_lvl   = 1'b0;
            raw_prev     = 1'b1;
            stable_cnt   = '0;
            press_cnt    = '0;
            window_cnt   = '0;
            pressed      = 1'b0;
            long_done    = 1'b0;
            hold_done    = 1'b0;
            short_armed  = 1'b0;
            latched      = EV_NONE;
            errors       = 0;
            ticks        = 0;
            short_n      = 0;
            long_n       = 0;
            double_n     = 0;
            hold_n       = 0;
        endfunction

        // register write, unknown indexes are dropped
        function void set_reg(t_cfg_idx idx, t_cfg_data val);
            case (idx)
                CFG_DEBOUNCE: debounce_thr = val;
                CFG_LONG:     long_thr     = val;
                CFG_DOUBLE:   double_thr   = val;
                CFG_HOLD:     hold_thr     = val;
                CFG_ACTIVE:   active_lvl   = val[0];
                default: ;
            endcase
        endfunction

        // elapsed counter step, sticks at all ones
        function t_timer bump(t_timer v);
            return (&v) ? v : v + t_timer'(1);
        endfunction

        // one poll tick: debounce, classify, queue the latched code
        function void note_tick(logic level, logic fetch);
            ticks++;
            stable_cnt = bump(stable_cnt);
            press_cnt  = bump(press_cnt);
            window_cnt = bump(window_cnt);

            if (level != raw_prev) begin
                stable_cnt = '0;
                raw_prev   = level;
            end else if (stable_cnt >= t_timer'(debounce_thr)) begin
                if (level == active_lvl) begin
                    if (!pressed) begin
                        pressed   = 1'b1;
                        long_done = 1'b0;
                        hold_done = 1'b0;
                        press_cnt = '0;
                    end else if (!hold_done && press_cnt >= t_timer'(hold_thr)) begin
                        latched     = EV_HOLD;
                        hold_done   = 1'b1;
                        short_armed = 1'b0;
                    end else if (!long_done && press_cnt >= t_timer'(long_thr)) begin
                        latched   = EV_LONG;
                        long_done = 1'b1;
                    end
                end else begin
                    // release of a press that reported nothing yet
                    if (pressed && !long_done && !hold_done) begin
                        if (short_armed && window_cnt <= t_timer'(double_thr)) begin
                            latched     = EV_DOUBLE;
                            short_armed = 1'b0;
                        end else begin
                            short_armed = 1'b1;
                            window_cnt  = '0;
                        end
                    end
                    pressed   = 1'b0;
                    long_done = 1'b1;
                    hold_done = 1'b1;
                end
            end

            // double window ran out
            if (short_armed && window_cnt > t_timer'(double_thr)) begin
                latched     = EV_SHORT;
                short_armed = 1'b0;
            end

            event_q.push_back(latched);
            if (fetch) begin
                latched = EV_NONE;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("tb: mismatch %0d at %0t: %s", errors, $time, msg);
            end
        endtask

        task check_event(logic [EVENT_BITS-1:0] got);
            t_event want;
            if (event_q.size() == 0) begin
                report($sformatf("event_code %0d with no word outstanding", got));
            end else begin
                want = event_q.pop_front();
                if (got !== want) begin
                    report($sformatf("event_code got %0d expected %0d", got, want));
                end
            end
            case (got)
                EV_SHORT:  short_n++;
                EV_LONG:   long_n++;
                EV_DOUBLE: double_n++;
                EV_HOLD:   hold_n++;
                default: ;
            endcase
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    t_cfg_idx           i_cfg_idx;
    t_cfg_data          i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic               i_button_level;
    logic               i_fetch;
    logic               o_valid;
    logic               i_stall;
    t_event             o_event_code;

    press_event_board   board = new();
    bit                 send_idle;
    bit                 recv_idle;
    bit                 hold_off_req;
    int                 quiet_cycles;
    int                 words_sent;
    int                 settings_n;
    int                 phase;

    button_press_classifier_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_button_level (i_button_level),
        .i_fetch        (i_fetch),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_code   (o_event_code)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // accepted words on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            board.note_tick(i_button_level, i_fetch);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_event(o_event_code);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall before each word, one long hold-off on request
    initial begin
        int wait_n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                wait_n       = HOLD_OFF_CYCLES;
            end else begin
                wait_n = recv_idle ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function bit rnd_fetch();
        return ($urandom_range(0, 3) == 0);
    endfunction

    // offer one poll word after a random gap, hold it until taken
    task automatic send_tick(logic level, logic fetch);
        int gap;
        gap = send_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_button_level <= level;
        i_fetch        <= fetch;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    task automatic send_run(logic level, int count);
        repeat (count) send_tick(level, rnd_fetch());
    endtask

    // contact bounce ending on the opposite level
    task automatic bounce(logic level);
        repeat ($urandom_range(1, 3)) begin
            send_tick(level, rnd_fetch());
            send_tick(!level, rnd_fetch());
        end
    endtask

    // level and fetch given as strings of 0 and 1
    task automatic run_pattern(string lv, string fe);
        for (int k = 0; k < lv.len(); k++) begin
            send_tick(lv[k] == "1", fe[k] == "1");
        end
    endtask

    // stop offering, drain every predicted word, then a short pause
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    // full register set, optional write to an unused index last
    task automatic apply_settings(int deb, int lng, int dbl, int hld, logic act,
                                  bit spare);
        write_reg(CFG_DEBOUNCE, t_cfg_data'(deb));
        write_reg(CFG_LONG, t_cfg_data'(lng));
        write_reg(CFG_DOUBLE, t_cfg_data'(dbl));
        write_reg(CFG_HOLD, t_cfg_data'(hld));
        write_reg(CFG_ACTIVE, {15'($urandom_range(0, 32767)), act});
        if (spare) begin
            write_reg(t_cfg_idx'(IDX_SPARE), t_cfg_data'($urandom));
        end
        i_cfg_we <= 1'b0;
        settings_n++;
    endtask

    // press/release sequences shaped around the current thresholds
    task automatic run_random(int budget);
        int   target;
        int   deb;
        int   lng;
        int   dbl;
        int   hld;
        int   sel;
        int   len;
        bit   bouncy;
        logic act;
        target = words_sent + budget;
        deb    = int'(board.debounce_thr);
        lng    = int'(board.long_thr);
        dbl    = int'(board.double_thr);
        hld    = int'(board.hold_thr);
        act    = board.active_lvl;
        while (words_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise
                repeat ($urandom_range(1, 6)) begin
                    send_tick(1'($urandom_range(0, 1)), rnd_fetch());
                end
            end else begin
                bouncy = ($urandom_range(0, 2) == 0);
                if (bouncy) bounce(act);
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    len = $urandom_range(1, deb + lng + 1);
                end else if (sel < 8) begin
                    len = $urandom_range(deb + lng + 1, deb + hld + 2);
                end else begin
                    len = $urandom_range(deb + hld + 2, deb + hld + 6);
                end
                send_run(act, len);
                if (bouncy) bounce(!act);
                if ($urandom_range(0, 9) < 6) begin
                    len = $urandom_range(1, deb + dbl + 2);
                end else begin
                    len = $urandom_range(deb + dbl + 2, deb + dbl + 8);
                end
                send_run(!act, len);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_DEBOUNCE;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_button_level = 1'b1;
        i_fetch        = 1'b0;
        i_stall        = 1'b0;
        send_idle      = 1'b1;
        recv_idle      = 1'b1;
        hold_off_req   = 1'b0;
        quiet_cycles   = 0;
        words_sent     = 0;
        settings_n     = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds, then double, long and hold back to back
        run_pattern("10", "01");
        settle();
        apply_settings(0, 2, 5, 4, 1'b0, 1'b0);
        run_pattern("00110011111111000000011", "00000001001000000001001");
        settle();

        // random sequences over several settings and idling mixes
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            send_idle = (phase != 1 && phase != 3);
            recv_idle = (phase != 2 && phase != 3);
            case (phase)
                0: apply_settings(1, 6, 8, 14, 1'b0, 1'b0);
                2: apply_settings(0, 0, 0, 0, 1'b1, 1'b0);
                3: apply_settings(2, 10, 5, 4, 1'b1, 1'b1);
                5: apply_settings(3, 12, 15, 25, 1'b0, 1'b0);
                default: apply_settings($urandom_range(0, 3), $urandom_range(0, 12),
                                        $urandom_range(0, 15), $urandom_range(0, 25),
                                        1'($urandom_range(0, 1)), 1'b0);
            endcase
            // block fills up behind a long result-side hold-off
            if (phase == 1) hold_off_req = 1'b1;
            run_random(WORDS_PER_PHASE);
            settle();
        end

        $display("tb: %0d poll words over %0d register settings, with bounce and noise",
                 board.ticks, settings_n);
        $display("tb: results seen: short %0d, long %0d, double %0d, hold %0d",
                 board.short_n, board.long_n, board.double_n, board.hold_n);
        if (board.errors == 0 && board.event_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
